// ===== rtl/core/tad_pkg.sv =====
// ============================================================================
// tad_pkg: shared types and constants for the tar archive deframer
// Block geometry, header field positions, result kinds and channel payloads.
// ============================================================================
package tad_pkg;

    localparam int BLOCK_BYTES       = 512;
    localparam int NAME_BYTES        = 100;
    localparam int SIZE_FIELD_OFFSET = 124;
    localparam int SIZE_FIELD_BYTES  = 12;

    localparam int OFFSET_W = $clog2(BLOCK_BYTES);
    localparam int SIZE_W   = 36;

    typedef logic [OFFSET_W-1:0] offset_t;
    typedef logic [SIZE_W-1:0]   size_t;

    localparam offset_t LAST_OFFSET  = offset_t'(BLOCK_BYTES - 1);
    localparam offset_t NAME_END     = offset_t'(NAME_BYTES);
    localparam offset_t SIZE_FIRST   = offset_t'(SIZE_FIELD_OFFSET);
    localparam int      SIZE_LAST_I  = SIZE_FIELD_OFFSET + SIZE_FIELD_BYTES - 1;
    localparam offset_t SIZE_LAST    = offset_t'(SIZE_LAST_I);

    typedef enum logic [1:0] {
        KIND_NAME  = 2'd0,
        KIND_START = 2'd1,
        KIND_DATA  = 2'd2,
        KIND_END   = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  byte_value;
        size_t       file_size;
        logic        last_of_file;
    } out_item_t;

endpackage

// ===== rtl/core/tad_ifs.sv =====
// ============================================================================
// tad_ifs: valid/ready channels of the tar archive deframer
// One interface for the archive byte stream, one for the result stream.
// ============================================================================
interface tad_in_if
    import tad_pkg::*;
;
    logic     valid;
    logic     ready;
    in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface tad_out_if
    import tad_pkg::*;
;
    logic      valid;
    logic      ready;
    out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/tar_archive_deframer_top.sv =====
// ============================================================================
// tar_archive_deframer_top: byte-serial tar archive parser
// Splits a tar stream into name bytes, file starts, data bytes and archive end.
// ============================================================================
// Usage:
//   archive (sink)  : one archive byte per transfer, 512-byte blocks.
//   result  (source): at most one result per accepted byte: name byte, file
//                     start with the octal size, data byte (last flagged), or
//                     archive end.
//   Each byte is decoded in the cycle it is accepted and its result lands in
//   the output register, so a result appears in the cycle after its byte.
//   Throughput is one byte per cycle; the only limit is the single output
//   register. archive.ready stays high while that register is empty or is
//   being drained in the same cycle, so a stalled receiver holds one result
//   and then backpressures the byte stream.
//   Bytes that make no result (padding, header fields) are still accepted like any other byte.
//   After archive end all further bytes are taken and dropped until reset.
//   Reset (rst_n low, async) returns to header mode at block offset zero,
//   clears the zero-block count and empties the output register.
// ============================================================================
module tar_archive_deframer_top
    import tad_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    tad_in_if.sink          archive,
    tad_out_if.source       result
);

    // parser state
    offset_t    block_offset_reg,   block_offset_next;
    logic       data_mode_reg,      data_mode_next;
    logic       hdr_nonzero_reg,    hdr_nonzero_next;
    logic       name_ended_reg,     name_ended_next;
    size_t      size_acc_reg,       size_acc_next;
    logic       size_started_reg,   size_started_next;
    logic       size_stopped_reg,   size_stopped_next;
    size_t      bytes_left_reg,     bytes_left_next;
    logic [1:0] zero_count_reg,     zero_count_next;
    logic       finished_reg,       finished_next;

    // output register
    logic       out_valid_reg,      out_valid_next;
    out_item_t  out_item_reg,       out_item_next;

    logic       fire;
    logic [7:0] c;
    logic       block_end;
    logic       emit;
    out_item_t  item;
    logic       in_size_field;
    logic       is_digit;
    logic       is_space;
    size_t      acc_step;
    logic [1:0] zero_count_inc;

    assign archive.ready  = !out_valid_reg || result.ready;
    assign fire           = archive.valid && archive.ready;
    assign c              = archive.payload.data_byte;
    assign block_end      = (block_offset_reg == LAST_OFFSET);

    assign in_size_field  = (block_offset_reg >= SIZE_FIRST) && (block_offset_reg <= SIZE_LAST);
    assign is_digit       = (c >= 8'h30) && (c <= 8'h37);
    assign is_space       = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    assign acc_step       = {size_acc_reg[SIZE_W-4:0], c[2:0]};
    assign zero_count_inc = (zero_count_reg == 2'd2) ? zero_count_reg : zero_count_reg + 2'd1;

    always_comb
    begin
        block_offset_next = block_offset_reg;
        data_mode_next    = data_mode_reg;
        hdr_nonzero_next  = hdr_nonzero_reg;
        name_ended_next   = name_ended_reg;
        size_acc_next     = size_acc_reg;
        size_started_next = size_started_reg;
        size_stopped_next = size_stopped_reg;
        bytes_left_next   = bytes_left_reg;
        zero_count_next   = zero_count_reg;
        finished_next     = finished_reg;
        emit              = 1'b0;
        item              = '{kind: KIND_NAME, byte_value: 8'd0, file_size: '0,
                              last_of_file: 1'b0};

        if (fire && !finished_reg)
        begin
            block_offset_next = block_end ? '0 : block_offset_reg + offset_t'(1);

            if (data_mode_reg)
            begin
                if (bytes_left_reg != '0)
                begin
                    emit              = 1'b1;
                    item.kind         = KIND_DATA;
                    item.byte_value   = c;
                    item.last_of_file = (bytes_left_reg == size_t'(1));
                    bytes_left_next   = bytes_left_reg - size_t'(1);
                end
                if (block_end && (bytes_left_next == '0))
                begin
                    data_mode_next = 1'b0;
                end
            end
            else
            begin
                hdr_nonzero_next = hdr_nonzero_reg || (c != 8'd0);

                if ((block_offset_reg < NAME_END) && !name_ended_reg)
                begin
                    if (c == 8'd0)
                    begin
                        name_ended_next = 1'b1;
                    end
                    else
                    begin
                        emit            = 1'b1;
                        item.kind       = KIND_NAME;
                        item.byte_value = c;
                    end
                end

                // strtol-style base 8: skip leading blanks, stop at first non-digit
                if (in_size_field && !size_stopped_reg)
                begin
                    if (is_digit)
                    begin
                        size_acc_next     = acc_step;
                        size_started_next = 1'b1;
                    end
                    else if (!(is_space && !size_started_reg))
                    begin
                        size_stopped_next = 1'b1;
                    end
                end

                if (block_end)
                begin
                    if (hdr_nonzero_next)
                    begin
                        emit            = 1'b1;
                        item.kind       = KIND_START;
                        item.byte_value = 8'd0;
                        item.file_size  = size_acc_next;
                        bytes_left_next = size_acc_next;
                        data_mode_next  = (size_acc_next != '0);
                    end
                    else
                    begin
                        zero_count_next = zero_count_inc;
                        if (zero_count_inc == 2'd2)
                        begin
                            emit          = 1'b1;
                            item.kind     = KIND_END;
                            finished_next = 1'b1;
                        end
                    end
                    hdr_nonzero_next  = 1'b0;
                    name_ended_next   = 1'b0;
                    size_acc_next     = '0;
                    size_started_next = 1'b0;
                    size_stopped_next = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_item_next  = item;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_offset_reg <= '0;
            data_mode_reg    <= 1'b0;
            hdr_nonzero_reg  <= 1'b0;
            name_ended_reg   <= 1'b0;
            size_acc_reg     <= '0;
            size_started_reg <= 1'b0;
            size_stopped_reg <= 1'b0;
            bytes_left_reg   <= '0;
            zero_count_reg   <= 2'd0;
            finished_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            block_offset_reg <= block_offset_next;
            data_mode_reg    <= data_mode_next;
            hdr_nonzero_reg  <= hdr_nonzero_next;
            name_ended_reg   <= name_ended_next;
            size_acc_reg     <= size_acc_next;
            size_started_reg <= size_started_next;
            size_stopped_reg <= size_stopped_next;
            bytes_left_reg   <= bytes_left_next;
            zero_count_reg   <= zero_count_next;
            finished_reg     <= finished_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_item_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_end_sets_finished: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_item_reg.kind == KIND_END)) |-> finished_reg)
        else $error("archive end shown without finished flag");

    a_last_only_on_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.last_of_file) |-> (out_item_reg.kind == KIND_DATA))
        else $error("last flag on a non-data result");

    a_finished_not_data: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |-> (!data_mode_reg && (zero_count_reg == 2'd2)))
        else $error("finished while in data mode or before two zero blocks");

    a_finished_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (finished_reg && $past(finished_reg)) |-> !emit)
        else $error("result produced after archive end");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top: self-checking bench for the tar archive deframer
// Drives a tar byte stream of 512-byte blocks and a ragged tail:
// hand-made headers for the size-field corner cases, then random members
// with random names, size encodings and data. A scoreboard class predicts
// every result from the accepted bytes; both channels idle at random, and
// the receiver once holds off long enough to stall the byte stream.
// ============================================================================
module tb_top;
    import tad_pkg::*;

    // Cycles with no transfer on either channel before the run is declared hung.
    // The worst quiet stretch is the one long receiver hold-off (HOLD_CYCLES)
    // plus one idle draw on each side.
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 150;
    localparam int RANDOM_BYTES = 800;
    localparam int MIN_MEMBERS  = 8;
    localparam int TAIL_CYCLES  = 8;

    // ------------------------------------------------------------------------
    // Scoreboard: a byte-level predictor of the deframer plus the queue of
    // results it expects, checked in order.
    // ------------------------------------------------------------------------
    class tar_stream_scoreboard;
        offset_t   offs;
        bit        data_mode;
        bit        hdr_nonzero;
        bit        name_done;
        bit        digits_seen;
        bit        parse_stopped;
        bit        finished;
        size_t     size_acc;
        size_t     left;
        bit [1:0]  zero_blocks;
        out_item_t expected[$];

        function new();
            offs        = '0;
            data_mode   = 1'b0;
            left        = '0;
            zero_blocks = '0;
            finished    = 1'b0;
            clear_hdr();
        endfunction

        function void clear_hdr();
            hdr_nonzero   = 1'b0;
            name_done     = 1'b0;
            size_acc      = '0;
            digits_seen   = 1'b0;
            parse_stopped = 1'b0;
        endfunction

        static function bit is_space(logic [7:0] c);
            return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
        endfunction

        function void note_byte(logic [7:0] c);
            out_item_t r;
            bit        emit;
            bit        blk_end;
            offset_t   off;
            if (finished)
                return;
            off     = offs;
            blk_end = (off == LAST_OFFSET);
            offs    = blk_end ? '0 : off + 1'b1;
            emit    = 1'b0;
            r       = '0;
            if (data_mode)
            begin
                if (left != 0)
                begin
                    r.kind         = KIND_DATA;
                    r.byte_value   = c;
                    r.last_of_file = (left == 1);
                    left           = left - 1'b1;
                    emit           = 1'b1;
                end
                // padding after the last byte is dropped up to the block end
                if (blk_end && left == 0)
                    data_mode = 1'b0;
            end
            else
            begin
                if (c != 8'h00)
                    hdr_nonzero = 1'b1;
                if (off < NAME_END && !name_done)
                begin
                    if (c == 8'h00)
                        name_done = 1'b1;
                    else
                    begin
                        r.kind       = KIND_NAME;
                        r.byte_value = c;
                        emit         = 1'b1;
                    end
                end
                // strtol-style octal: skip leading blanks, stop at any non-digit
                if (off >= SIZE_FIRST && off <= SIZE_LAST && !parse_stopped)
                begin
                    if (c >= 8'h30 && c <= 8'h37)
                    begin
                        size_acc    = (size_acc << 3) | size_t'(c[2:0]);
                        digits_seen = 1'b1;
                    end
                    else if (digits_seen || !is_space(c))
                        parse_stopped = 1'b1;
                end
                if (blk_end)
                begin
                    if (hdr_nonzero)
                    begin
                        r           = '0;
                        r.kind      = KIND_START;
                        r.file_size = size_acc;
                        emit        = 1'b1;
                        left        = size_acc;
                        data_mode   = (size_acc != 0);
                    end
                    else
                    begin
                        if (zero_blocks < 2)
                            zero_blocks++;
                        if (zero_blocks >= 2)
                        begin
                            r        = '0;
                            r.kind   = KIND_END;
                            emit     = 1'b1;
                            finished = 1'b1;
                        end
                    end
                    clear_hdr();
                end
            end
            if (emit)
                expected.push_back(r);
        endfunction

        function bit check_result(out_item_t got, output string msg);
            out_item_t want;
            msg = "";
            if (expected.size() == 0)
            begin
                $sformat(msg, "unexpected result kind=%0d byte=%02h size=%0d last=%0b",
                         got.kind, got.byte_value, got.file_size, got.last_of_file);
                return 1'b0;
            end
            want = expected.pop_front();
            if (got.kind !== want.kind)
                msg = {msg, $sformatf(" kind %0d/%0d", got.kind, want.kind)};
            if (got.byte_value !== want.byte_value)
                msg = {msg, $sformatf(" byte %02h/%02h", got.byte_value, want.byte_value)};
            if (got.file_size !== want.file_size)
                msg = {msg, $sformatf(" size %0d/%0d", got.file_size, want.file_size)};
            if (got.last_of_file !== want.last_of_file)
                msg = {msg, $sformatf(" last %0b/%0b", got.last_of_file, want.last_of_file)};
            if (msg != "")
            begin
                msg = {"field mismatch (got/exp):", msg};
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function int pending();
            return expected.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    tad_in_if  archive_ch ();
    tad_out_if result_ch ();

    tar_archive_deframer_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .archive (archive_ch),
        .result  (result_ch)
    );

    tar_stream_scoreboard sb = new();

    int          mismatches   = 0;
    int          results_seen = 0;
    int          stall_cycles = 0;
    int unsigned bytes_sent   = 0;
    bit          fast_tx      = 1'b0;   // sender stretch with no idle cycles
    bit          fast_rx      = 1'b0;   // receiver stretch with ready held high
    bit          hold_done    = 1'b0;

    // Header under construction, sent as one 512-byte block.
    logic [7:0] hbuf [0:BLOCK_BYTES-1];

    task automatic report_mismatch(input string msg);
        $display("tb_top: mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Transfer monitor. Sampling at the rising edge sees the values driven
    // before the edge, since every driver here uses nonblocking assignments.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : xfer_monitor
        string msg;
        if (rst_n)
        begin
            if (archive_ch.valid && archive_ch.ready)
                sb.note_byte(archive_ch.payload.data_byte);
            if (result_ch.valid && result_ch.ready)
            begin
                results_seen++;
                if (!sb.check_result(result_ch.payload, msg))
                    report_mismatch(msg);
            end
        end
    end

    // Watchdog: any transfer on either side restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n)
            stall_cycles <= 0;
        else if ((archive_ch.valid && archive_ch.ready) || (result_ch.valid && result_ch.ready))
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random idle before each transfer, occasional no-idle bursts,
    // and one long hold-off so the output register fills and the byte
    // stream backs up behind it.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned gap;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            gap = fast_rx ? 0 : $urandom_range(0, 14);
            if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                gap       = HOLD_CYCLES;
            end
            if (gap != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid)
                @(posedge clk);
            if ($urandom_range(0, 47) == 0)
                fast_rx = !fast_rx;
        end
    end

    // ------------------------------------------------------------------------
    // Stream builders
    // ------------------------------------------------------------------------

    // One byte; valid stays high across back-to-back transfers.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = fast_tx ? 0 : $urandom_range(0, 14);
        if (gap != 0)
        begin
            archive_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        archive_ch.valid             <= 1'b1;
        archive_ch.payload.data_byte <= b;
        @(posedge clk);
        while (!archive_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_block();
        fast_tx = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < BLOCK_BYTES; i++)
            send_byte(hbuf[i]);
    endtask

    // Member data rounded up to whole blocks; padding is random too.
    task automatic send_payload(input size_t n);
        longint unsigned total;
        total = ((longint'(n) + BLOCK_BYTES - 1) / BLOCK_BYTES) * BLOCK_BYTES;
        for (longint unsigned i = 0; i < total; i++)
        begin
            if (i % BLOCK_BYTES == 0)
                fast_tx = ($urandom_range(0, 3) == 0);
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_member(input size_t sz);
        send_block();
        if (sz != 0)
            send_payload(sz);
    endtask

    task automatic clear_hbuf();
        for (int i = 0; i < BLOCK_BYTES; i++)
            hbuf[i] = 8'h00;
    endtask

    // Name of len non-NUL bytes; junk after the terminating NUL must be ignored.
    task automatic fill_name(input int len, input bit junk);
        for (int i = 0; i < len; i++)
            hbuf[i] = 8'($urandom_range(1, 255));
        if (junk)
            for (int i = len + 1; i < NAME_BYTES; i++)
                hbuf[i] = 8'($urandom_range(0, 255));
    endtask

    // Random bytes in the header fields the block does not parse.
    task automatic fill_junk();
        for (int i = NAME_BYTES; i < SIZE_FIELD_OFFSET; i++)
            hbuf[i] = 8'($urandom_range(0, 255));
        for (int i = SIZE_LAST_I + 1; i < BLOCK_BYTES; i++)
            hbuf[i] = 8'($urandom_range(0, 255));
    endtask

    function automatic logic [7:0] space_char(input int k);
        case (k)
            0:       return 8'h20;
            1:       return 8'h09;
            2:       return 8'h0A;
            3:       return 8'h0B;
            4:       return 8'h0C;
            default: return 8'h0D;
        endcase
    endfunction

    // A character that ends the octal parse. Blanks only stop it after a digit.
    function automatic logic [7:0] stop_char(input bit after_digits);
        case ($urandom_range(0, after_digits ? 9 : 6))
            0:       return 8'h00;
            1:       return 8'h2B;                          // '+'
            2:       return 8'h2D;                          // '-'
            3:       return 8'h38;                          // '8'
            4:       return 8'h39;                          // '9'
            5:       return 8'($urandom_range(8'h80, 8'hFF));
            6:       return 8'($urandom_range(8'h3A, 8'h7F));
            7:       return 8'h20;
            8:       return 8'h09;
            default: return 8'h0D;
        endcase
    endfunction

    // Size field: ws leading blanks, value v as 'digits' octal digits (zero
    // padded), a stop character, then anything at all.
    task automatic fill_size(input size_t v, input int ws, input int digits);
        int pos;
        int rot;
        pos = SIZE_FIELD_OFFSET;
        rot = $urandom_range(0, 5);
        for (int i = 0; i < ws; i++)
        begin
            hbuf[pos] = space_char((i + rot) % 6);
            pos++;
        end
        for (int i = 0; i < digits; i++)
        begin
            hbuf[pos] = 8'h30 + 8'((v >> (3 * (digits - 1 - i))) & 36'h7);
            pos++;
        end
        if (pos <= SIZE_LAST_I)
        begin
            hbuf[pos] = stop_char(digits != 0);
            pos++;
        end
        while (pos <= SIZE_LAST_I)
        begin
            hbuf[pos] = 8'($urandom_range(0, 255));
            pos++;
        end
    endtask

    function automatic int oct_digits(input size_t v);
        int n;
        n = 1;
        while (v > 7)
        begin
            v = v >> 3;
            n++;
        end
        return n;
    endfunction

    // Member sizes stay small; zero and whole-block sizes are common.
    function automatic size_t pick_size();
        case ($urandom_range(0, 19))
            0, 1, 2:                  return '0;
            3, 4, 5, 6, 7, 8:         return size_t'($urandom_range(1, 20));
            9, 10, 11, 12, 13, 14, 15,
            16:                       return size_t'($urandom_range(21, 700));
            17:                       return size_t'(BLOCK_BYTES);
            18:                       return size_t'(2 * BLOCK_BYTES);
            default:                  return size_t'(BLOCK_BYTES + $urandom_range(0, 2) - 1);
        endcase
    endfunction

    task automatic random_member();
        size_t sz;
        int    nd;
        int    ws;
        int    digits;
        int    name_len;
        sz = pick_size();
        clear_hbuf();
        name_len = ($urandom_range(0, 3) == 0) ? NAME_BYTES : $urandom_range(0, NAME_BYTES);
        fill_name(name_len, $urandom_range(0, 1));
        if ($urandom_range(0, 1))
            fill_junk();
        hbuf[257] = 8'h75;      // 'u' of the ustar magic; never an all-zero header
        nd     = oct_digits(sz);
        ws     = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 12 - nd) : 0;
        digits = nd + $urandom_range(0, 12 - nd - ws);
        if (sz == 0 && $urandom_range(0, 2) == 0)
            digits = 0;         // no digit at all still parses as zero
        fill_size(sz, ws, digits);
        send_member(sz);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        size_t       sz;
        int unsigned rnd_start;
        int          members;

        rst_n                <= 1'b0;
        archive_ch.valid     <= 1'b0;
        archive_ch.payload   <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full-length name with the byte extremes, twelve digits, no stop
        // character, and a size of exactly one block.
        clear_hbuf();
        fill_name(NAME_BYTES, 1'b0);
        hbuf[0]              = 8'hFF;
        hbuf[NAME_BYTES - 1] = 8'h01;
        fill_size(size_t'(BLOCK_BYTES), 0, 12);
        send_member(size_t'(BLOCK_BYTES));

        // All six leading blanks, then "17" and a NUL.
        clear_hbuf();
        fill_name(1, 1'b0);
        fill_size(size_t'(15), 6, 2);
        hbuf[SIZE_FIELD_OFFSET + 8] = 8'h00;
        send_member(size_t'(15));

        // Empty name with junk behind the NUL; a leading '+' gives size zero,
        // so the block stays in header mode.
        clear_hbuf();
        fill_name(0, 1'b1);
        hbuf[5]                     = 8'h41;
        hbuf[SIZE_FIELD_OFFSET]     = 8'h2B;
        hbuf[SIZE_FIELD_OFFSET + 1] = 8'h31;
        hbuf[SIZE_FIELD_OFFSET + 2] = 8'h32;
        send_member('0);

        // Plain "0".
        clear_hbuf();
        fill_name(1, 1'b0);
        fill_size('0, 0, 1);
        send_member('0);

        // Header whose only non-zero byte is the very last one.
        clear_hbuf();
        hbuf[BLOCK_BYTES - 1] = 8'h01;
        send_member('0);

        // First all-zero block: counted, no result. A second one, sent at the
        // very end in one of the two endings, is not adjacent to it.
        clear_hbuf();
        send_block();

        // A blank after the first digit stops the parse: "1 7" is one byte.
        clear_hbuf();
        fill_name(3, 1'b1);
        hbuf[SIZE_FIELD_OFFSET]     = 8'h31;
        hbuf[SIZE_FIELD_OFFSET + 1] = 8'h20;
        hbuf[SIZE_FIELD_OFFSET + 2] = 8'h37;
        send_member(size_t'(1));

        // "2000" then '8': two whole blocks.
        clear_hbuf();
        fill_name(7, 1'b0);
        fill_junk();
        fill_size(size_t'(1024), 0, 4);
        hbuf[SIZE_FIELD_OFFSET + 4] = 8'h38;
        send_member(size_t'(1024));

        // "1001" then '-': the last byte opens the second block.
        clear_hbuf();
        fill_name(20, 1'b1);
        fill_size(size_t'(513), 0, 4);
        hbuf[SIZE_FIELD_OFFSET + 4] = 8'h2D;
        send_member(size_t'(513));

        // Leading '-' parses nothing.
        clear_hbuf();
        fill_name(2, 1'b0);
        hbuf[SIZE_FIELD_OFFSET]     = 8'h2D;
        hbuf[SIZE_FIELD_OFFSET + 1] = 8'h35;
        send_member('0);

        // Random members: whole well-formed headers with random content.
        rnd_start = bytes_sent;
        members   = 0;
        while ((bytes_sent - rnd_start) < RANDOM_BYTES || members < MIN_MEMBERS)
        begin
            random_member();
            members++;
        end

        // Both endings are terminal, so each run takes one of them: archive
        // end followed by ignored bytes, or a member with a size up in the
        // top octal digit whose data never finishes.
        if ($urandom_range(0, 1))
        begin
            clear_hbuf();
            send_block();
            repeat (40) send_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            clear_hbuf();
            fill_name($urandom_range(1, NAME_BYTES), 1'b0);
            sz     = size_t'({$urandom(), $urandom()});
            sz[35] = 1'b1;
            fill_size(sz, 0, 12);
            send_block();
            repeat (600) send_byte(8'($urandom_range(0, 255)));
        end
        archive_ch.valid <= 1'b0;

        // Drain; the watchdog catches results that never come.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && sb.pending() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
